@@ src/gwws_pkg.sv @@
// ----------------------------------------------------------------------------
// gwws_pkg: shared constants and types
// Widths, defaults and register indexes for the window smoother.
// ----------------------------------------------------------------------------
package gwws_pkg;

    localparam int WINDOW_MAX_DEF = 30;
    localparam int AXIS_COUNT_DEF = 4;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 17;
    localparam int ACC_W    = 40;
    localparam int WSUM_W   = 24;
    localparam int CFG_W    = 7;

    localparam logic [2:0] REG_LEFT_ENABLE  = 3'd0;
    localparam logic [2:0] REG_RIGHT_ENABLE = 3'd1;
    localparam logic [2:0] REG_LEFT_WINDOW  = 3'd2;
    localparam logic [2:0] REG_RIGHT_WINDOW = 3'd3;
    localparam logic [2:0] REG_LEFT_DECAY   = 3'd4;
    localparam logic [2:0] REG_RIGHT_DECAY  = 3'd5;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

    // pct*65536/100 = pct*2^14/25; 2684355 = ceil(2^26/25), exact for pct <= 100
    localparam int               DECAY_RECIP_W = 22;
    localparam int               DECAY_PROD_W  = CFG_W + DECAY_RECIP_W;
    localparam logic [DECAY_RECIP_W-1:0] DECAY_RECIP = 22'd2684355;
    localparam int               DECAY_SHIFT   = 12;

    typedef struct packed {
        logic              start;
        logic signed [ACC_W-1:0]  num;
        logic [WSUM_W-1:0] den;
    } div_req_t;

    // floor(pct*65536/100) for pct 0..127, saturated at 100
    function automatic logic [WEIGHT_W-1:0] decay_ratio(input logic [CFG_W-1:0] pct);
        logic [CFG_W-1:0] p;
        logic [DECAY_PROD_W-1:0] prod;
        p = (pct > 7'd100) ? 7'd100 : pct;
        prod = DECAY_PROD_W'(p) * DECAY_RECIP;
        return WEIGHT_W'(prod >> DECAY_SHIFT);
    endfunction

endpackage

@@ src/geometric_weighted_window_smoother.sv @@
// ----------------------------------------------------------------------------
// geometric_weighted_window_smoother: per-axis decaying window average
// Channel  | direction | signals
// in       | input     | in_valid, in_ready, axis_index, sample
// out      | output    | out_valid, out_ready, smoothed
// cfg      | input     | cfg_we, cfg_index, cfg_data
// Passthrough items are registered straight to the output. Smoothed items
// (N = window size) walk the N window entries with one shared multiplier,
// one entry at a time (memory read, then multiply-accumulate), then go
// through a bit-serial divider. A config write clears a stick's windows by
// sweeping its window entries while in_ready stays low.
// Reset sets control registers to defaults and clears window state via that
// same sweep over all axes. A stalled result holds; input stays blocked.
// ----------------------------------------------------------------------------
module geometric_weighted_window_smoother
    import gwws_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int AXIS_COUNT = AXIS_COUNT_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 axis_index,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] smoothed,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    localparam int DEPTH  = AXIS_COUNT * WINDOW_MAX;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int AX_W   = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
    localparam int N_W    = $clog2(WINDOW_MAX + 1);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_MAC   = 4'd3;
    localparam logic [3:0] ST_DIVGO = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_OUT   = 4'd6;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rd_reg;

    logic [3:0]  state_reg, state_next;
    logic        len_reg, ren_reg;
    logic [4:0]  lwin_reg, rwin_reg;
    logic [CFG_W-1:0] ldec_reg, rdec_reg;
    logic [SLOT_W-1:0] head_reg [AXIS_COUNT];

    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next, clr_end_reg, clr_end_next;
    logic              pend_l_reg, pend_r_reg;

    logic [AX_W-1:0]   ax_reg;
    logic [N_W-1:0]    n_reg;
    logic [N_W-1:0]    k_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [WEIGHT_W-1:0] r_reg, w_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [WSUM_W-1:0] wsum_reg;
    logic signed [SAMPLE_W-1:0] res_reg;
    logic              ovalid_reg;

    logic signed [SAMPLE_W+WEIGHT_W:0] prod;
    logic [2*WEIGHT_W-1:0] wprod;
    div_req_t dreq;
    logic     ddone;
    logic signed [ACC_W-1:0] dq;

    logic        take;
    logic        ax_ok, en_sel;
    logic [4:0]  win_sel;
    logic [N_W-1:0] n_eff;
    logic [SLOT_W-1:0] slot0, slot_new;
    logic [ADDR_W-1:0] base;
    logic        we;
    logic [ADDR_W-1:0] waddr;
    logic signed [SAMPLE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
    logic        cfg_hit, cfg_stick;
    logic        clr_go;

    gwws_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .done (ddone),
        .quot (dq)
    );

    assign in_ready  = (state_reg == ST_IDLE) && !ovalid_reg && !pend_l_reg && !pend_r_reg;
    assign take      = in_valid && in_ready;
    assign out_valid = ovalid_reg;
    assign smoothed  = res_reg;

    assign ax_ok   = ({2'b00, axis_index} < 4'(AXIS_COUNT));
    assign en_sel  = axis_index[1] ? ren_reg : len_reg;
    assign win_sel = axis_index[1] ? rwin_reg : lwin_reg;
    assign n_eff   = (win_sel == 5'd0) ? N_W'(1) :
                     ({27'd0, win_sel} > 32'(WINDOW_MAX)) ? N_W'(WINDOW_MAX) : N_W'(win_sel);
    assign slot0   = ({{(32-SLOT_W){1'b0}}, head_reg[AX_W'(axis_index)]} >= 32'(n_eff))
                     ? '0 : head_reg[AX_W'(axis_index)];
    assign slot_new = ({{(32-SLOT_W){1'b0}}, slot0} + 32'd1 >= 32'(n_eff))
                     ? '0 : slot0 + 1'b1;
    assign base    = ADDR_W'(32'(AX_W'(axis_index)) * WINDOW_MAX);

    assign cfg_hit   = cfg_we && (cfg_index <= REG_RIGHT_DECAY);
    assign cfg_stick = cfg_index[0];
    assign clr_go    = (state_reg == ST_IDLE) && (pend_l_reg || pend_r_reg);

    assign prod  = $signed(rd_reg) * $signed({1'b0, w_reg});
    assign wprod = w_reg * r_reg;

    always_comb
    begin
        raddr = ADDR_W'(32'(ax_reg) * WINDOW_MAX + 32'(idx_reg));
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        clr_end_next  = clr_end_reg;
        we    = 1'b0;
        waddr = clr_addr_reg;
        wdata = '0;
        dreq.start = 1'b0;
        dreq.num   = acc_reg;
        dreq.den   = wsum_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == clr_end_reg)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (pend_l_reg || pend_r_reg)
                begin
                    state_next = ST_CLEAR;
                    clr_addr_next = pend_l_reg ? '0 : ADDR_W'(32'(AXIS_COUNT > 2 ? 2 : 0) * WINDOW_MAX);
                    clr_end_next  = pend_l_reg ?
                        ADDR_W'(32'(AXIS_COUNT > 1 ? 2 : 1) * WINDOW_MAX - 1) :
                        ADDR_W'(DEPTH - 1);
                end
                else if (take && ax_ok && en_sel)
                begin
                    we    = 1'b1;
                    waddr = ADDR_W'(32'(base) + 32'(slot_new));
                    wdata = sample;
                    state_next = ST_READ;
                end
            end
            ST_READ:
                state_next = ST_MAC;
            ST_MAC:
                state_next = (k_reg == n_reg - 1'b1) ? ST_DIVGO : ST_READ;
            ST_DIVGO:
            begin
                dreq.start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
                if (ddone)
                    state_next = ST_OUT;
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            clr_end_reg  <= ADDR_W'(DEPTH - 1);
            pend_l_reg   <= 1'b0;
            pend_r_reg   <= 1'b0;
            len_reg      <= 1'b0;
            ren_reg      <= 1'b0;
            lwin_reg     <= 5'd1;
            rwin_reg     <= 5'd1;
            ldec_reg     <= 7'd100;
            rdec_reg     <= 7'd100;
            ovalid_reg   <= 1'b0;
            for (int i = 0; i < AXIS_COUNT; i++)
                head_reg[i] <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_end_reg  <= clr_end_next;
            // left sweep goes first when both sticks are pending
            pend_l_reg <= (pend_l_reg && !clr_go) || (cfg_hit && !cfg_stick);
            pend_r_reg <= (pend_r_reg && !(clr_go && !pend_l_reg)) ||
                          (cfg_hit && cfg_stick && (AXIS_COUNT > 2));
            if (cfg_hit)
            begin
                unique case (cfg_index)
                    REG_LEFT_ENABLE:  len_reg  <= cfg_data[0];
                    REG_RIGHT_ENABLE: ren_reg  <= cfg_data[0];
                    REG_LEFT_WINDOW:  lwin_reg <= cfg_data[4:0];
                    REG_RIGHT_WINDOW: rwin_reg <= cfg_data[4:0];
                    REG_LEFT_DECAY:   ldec_reg <= cfg_data;
                    REG_RIGHT_DECAY:  rdec_reg <= cfg_data;
                    default: ;
                endcase
                for (int i = 0; i < AXIS_COUNT; i++)
                    if ((i >> 1) == int'(cfg_stick))
                        head_reg[i] <= '0;
            end
            if (!cfg_hit && take && ax_ok && en_sel && !pend_l_reg && !pend_r_reg)
                head_reg[AX_W'(axis_index)] <= slot_new;
            if (take && !(ax_ok && en_sel))
                ovalid_reg <= 1'b1;
            else if (state_reg == ST_OUT)
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ax_reg   <= AX_W'(axis_index);
            n_reg    <= n_eff;
            k_reg    <= '0;
            idx_reg  <= slot_new;
            r_reg    <= decay_ratio(axis_index[1] ? rdec_reg : ldec_reg);
            w_reg    <= WEIGHT_ONE;
            acc_reg  <= '0;
            wsum_reg <= '0;
            res_reg  <= sample;
        end
        else if (state_reg == ST_MAC)
        begin
            acc_reg  <= acc_reg + ACC_W'(prod);
            wsum_reg <= wsum_reg + WSUM_W'(w_reg);
            w_reg    <= wprod[2*WEIGHT_W-1-1 -: WEIGHT_W] >> 0;
            k_reg    <= k_reg + 1'b1;
            idx_reg  <= (idx_reg == '0) ? SLOT_W'(n_reg - 1'b1) : idx_reg - 1'b1;
        end
        else if (ddone)
        begin
            res_reg <= (dq > 40'sd32767) ? 16'sh7fff :
                       (dq < -40'sd32768) ? 16'sh8000 : SAMPLE_W'(dq);
        end
    end

endmodule

@@ src/gwws_divider.sv @@
// ----------------------------------------------------------------------------
// gwws_divider: restoring signed floor divider
// One quotient bit per cycle; floor rounding toward minus infinity.
// ----------------------------------------------------------------------------
module gwws_divider
    import gwws_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  div_req_t                 req,
    output logic                     done,
    output logic signed [ACC_W-1:0]  quot
);

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]  rem_reg, rem_next;
    logic [ACC_W-1:0]  q_reg, q_next;
    logic [ACC_W-1:0]  dend_reg, dend_next;
    logic [WSUM_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ACC_W:0]    trial;
    logic [ACC_W-1:0]  qfix;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        dend_next = dend_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dend_reg[ACC_W-1]} - {{(ACC_W+1-WSUM_W){1'b0}}, den_reg};
        if (req.start)
        begin
            neg_next  = req.num[ACC_W-1];
            dend_next = req.num[ACC_W-1] ? ACC_W'(-req.num) : ACC_W'(req.num);
            den_next  = req.den;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = CNT_W'(ACC_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dend_next = {dend_reg[ACC_W-2:0], 1'b0};
            if (!trial[ACC_W])
            begin
                rem_next = trial[ACC_W-1:0];
                q_next   = {q_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[ACC_W-2:0], dend_reg[ACC_W-1]};
                q_next   = {q_reg[ACC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        dend_reg <= dend_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
    end

    // negative: -(q) or -(q+1) when remainder nonzero
    assign qfix = (rem_reg != '0) ? q_reg + 1'b1 : q_reg;
    assign quot = neg_reg ? -$signed(qfix) : $signed(q_reg);
    assign done = done_reg;

endmodule

@@ src/gwws_checker.sv @@
// ----------------------------------------------------------------------------
// gwws_checker: port-level checks for the window smoother
// Watches handshakes and result stability at the top level ports.
// ----------------------------------------------------------------------------
module gwws_checker
    import gwws_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] smoothed
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(smoothed))
        else $error("result dropped or changed while stalled");

    a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while result pending");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready held after transfer");

endmodule

bind geometric_weighted_window_smoother gwws_checker u_gwws_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .smoothed (smoothed)
);

@@ sim/geometric_weighted_window_smoother_tb.sv @@
// ----------------------------------------------------------------------------
// geometric_weighted_window_smoother_tb: regression for the window smoother
// Drives axis samples with random gaps, predicts each smoothed value from a
// behavioral copy of the windows and registers, and checks every output
// transfer in order. Registers change only while the block is idle.
// ----------------------------------------------------------------------------
module geometric_weighted_window_smoother_tb
    import gwws_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 axis_index;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [SAMPLE_W-1:0] smoothed;
    logic                       cfg_we;
    logic [2:0]                 cfg_index;
    logic [CFG_W-1:0]           cfg_data;

    geometric_weighted_window_smoother dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .axis_index(axis_index), .sample(sample),
        .out_valid(out_valid), .out_ready(out_ready), .smoothed(smoothed),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam int WMAX = 30;
    localparam int CYCLE_LIMIT = 2000000;

    logic [6:0]  reg_file [6];
    logic signed [15:0] win_mem [4][WMAX];
    int          win_head [4];
    logic signed [15:0] expected_q [$];
    int          errors;
    int          cycles;
    int          stall_cnt;
    logic        draining;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("geometric_weighted_window_smoother regression: fail");
            $finish;
        end
    end

    task automatic clear_stick_model(input int stick);
        for (int a = 0; a < 4; a++)
            if ((a >> 1) == stick)
            begin
                for (int k = 0; k < WMAX; k++)
                    win_mem[a][k] = '0;
                win_head[a] = 0;
            end
    endtask

    function automatic logic signed [15:0] smooth_predict(input logic [1:0] ax,
                                                         input logic signed [15:0] s);
        int right;
        int n;
        int pct;
        longint r;
        longint w;
        longint wsum;
        longint acc;
        longint q;
        int slot;
        right = ax >> 1;
        if (reg_file[REG_LEFT_ENABLE + right][0] == 1'b0)
            return s;
        n = reg_file[REG_LEFT_WINDOW + right][4:0];
        if (n == 0)
            n = 1;
        if (n > WMAX)
            n = WMAX;
        pct = reg_file[REG_LEFT_DECAY + right];
        if (pct > 100)
            pct = 100;
        r = (longint'(pct) * 65536) / 100;
        slot = win_head[ax];
        if (slot >= n)
            slot = 0;
        slot = (slot + 1) % n;
        win_head[ax] = slot;
        win_mem[ax][slot] = s;
        w = 65536;
        wsum = 0;
        acc = 0;
        for (int k = 0; k < n; k++)
        begin
            acc += longint'(win_mem[ax][(slot + n - k) % n]) * w;
            wsum += w;
            w = (w * r) / 65536;
        end
        q = acc / wsum;
        if ((acc % wsum) != 0 && acc < 0)
            q--;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return 16'(q);
    endfunction

    // random gap: mostly short, sometimes long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, actual %0d", $time, smoothed);
                errors++;
            end
            else
            begin
                if (smoothed !== expected_q[0])
                begin
                    $display("%0t: smoothed expected %0d actual %0d",
                             $time, expected_q[0], smoothed);
                    errors++;
                end
                void'(expected_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_cnt <= 0;
        end
        else if (draining)
            out_ready <= 1'b1;
        else if (stall_cnt > 0)
        begin
            out_ready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_cnt <= gap_len();
        end
    end

    task automatic send_sample(input logic [1:0] ax, input logic signed [15:0] s);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        axis_index <= ax;
        sample     <= s;
        expected_q.push_back(smooth_predict(ax, s));
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx <= REG_RIGHT_DECAY)
        begin
            case (idx)
                REG_LEFT_ENABLE, REG_RIGHT_ENABLE: reg_file[idx] = {6'b0, val[0]};
                REG_LEFT_WINDOW, REG_RIGHT_WINDOW: reg_file[idx] = {2'b0, val[4:0]};
                default:                           reg_file[idx] = val;
            endcase
            clear_stick_model(idx[0]);
        end
        repeat (200) @(posedge clk);
    endtask

    task automatic random_sample();
        logic signed [15:0] s;
        case ($urandom_range(0, 3))
            0: s = 16'sh7FFF;
            1: s = 16'sh8000;
            default: s = 16'($urandom);
        endcase
        send_sample(2'($urandom_range(0, 3)), s);
    endtask

    task automatic test_passthrough();
        send_sample(2'd0, 16'sh7FFF);
        send_sample(2'd1, 16'sh8000);
        send_sample(2'd2, 16'sh0000);
        send_sample(2'd3, 16'shFFFF);
        send_sample(2'd0, 16'sh5555);
        send_sample(2'd3, 16'shAAAA);
    endtask

    task automatic test_directed_extremes();
        write_reg(REG_LEFT_ENABLE, 7'd1);
        write_reg(REG_RIGHT_ENABLE, 7'd1);
        write_reg(REG_LEFT_WINDOW, 7'd30);
        write_reg(REG_RIGHT_WINDOW, 7'd0);
        for (int i = 0; i < 4; i++)
            send_sample(2'(i), 16'sh7FFF);
        send_sample(2'd0, 16'sh8000);
        send_sample(2'd2, 16'sh8000);
        write_reg(REG_LEFT_DECAY, 7'd0);
        write_reg(REG_RIGHT_DECAY, 7'd127);
        write_reg(REG_RIGHT_WINDOW, 7'd31);
        send_sample(2'd0, 16'sh1234);
        send_sample(2'd1, 16'sh8000);
        send_sample(2'd2, 16'sh7FFF);
        send_sample(2'd3, 16'sh8000);
        write_reg(3'd6, 7'h7F);
        write_reg(3'd7, 7'h00);
        send_sample(2'd3, 16'sh8001);
        write_reg(REG_LEFT_DECAY, 7'd100);
        write_reg(REG_LEFT_WINDOW, 7'd1);
        send_sample(2'd1, 16'sh4000);
        send_sample(2'd1, 16'shC000);
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 10; phase++)
        begin
            write_reg(REG_LEFT_ENABLE, 7'($urandom_range(0, 9) < 8));
            write_reg(REG_RIGHT_ENABLE, 7'($urandom));
            write_reg(REG_LEFT_WINDOW, 7'($urandom_range(0, 9) < 7 ?
                                          $urandom_range(0, 8) : $urandom_range(0, 127)));
            write_reg(REG_RIGHT_WINDOW, 7'($urandom_range(0, 9) < 7 ?
                                           $urandom_range(0, 8) : $urandom_range(0, 127)));
            write_reg(REG_LEFT_DECAY, 7'($urandom_range(0, 127)));
            write_reg(REG_RIGHT_DECAY, 7'($urandom_range(0, 4) == 0 ? 100 :
                                          $urandom_range(0, 127)));
            for (int i = 0; i < 50; i++)
                random_sample();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        axis_index = '0;
        sample     = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        draining   = 1'b0;
        errors     = 0;
        cycles     = 0;
        reg_file[0] = 7'd0;
        reg_file[1] = 7'd0;
        reg_file[2] = 7'd1;
        reg_file[3] = 7'd1;
        reg_file[4] = 7'd100;
        reg_file[5] = 7'd100;
        clear_stick_model(0);
        clear_stick_model(1);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_directed_extremes();
        test_random_settings();

        draining = 1'b1;
        wait_idle();
        if (errors == 0 && expected_q.size() == 0)
            $display("geometric_weighted_window_smoother regression: pass");
        else
            $display("geometric_weighted_window_smoother regression: fail");
        $finish;
    end

endmodule

@@ geometric_weighted_window_smoother.f @@
src/gwws_pkg.sv
src/gwws_divider.sv
src/geometric_weighted_window_smoother.sv
src/gwws_checker.sv
sim/geometric_weighted_window_smoother_tb.sv
